/* rtl/shld_pkg.sv */
// ----------------------------------------------------------------------------
// shld_pkg
// Types and constants shared by the sync header / length deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package shld_pkg;

	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam int unsigned CFG_DATA_BITS  = 32;
	localparam int unsigned SYNC_BITS      = 32;
	localparam int unsigned WINDOW_BITS    = 24;
	localparam int unsigned OVH_BITS       = 8;
	localparam int unsigned LEN_BITS       = 17;
	localparam int unsigned FRAME_OFF_BITS = 32;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] REG_SYNC_WORD       = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LENGTH_OVERHEAD = 2'd1;

	localparam logic [SYNC_BITS-1:0] SYNC_WORD_RESET = 32'hA55A_A55A;
	localparam logic [OVH_BITS-1:0]  OVH_RESET       = 8'd16;

	// sync plus the two length bytes are always part of the frame
	localparam logic [OVH_BITS-1:0] MIN_OVERHEAD = 8'd6;
	// bytes of a sync word that precede the matching byte
	localparam int unsigned SYNC_LEAD = 3;
	localparam logic [1:0]  FILL_FULL = 2'd3;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_BODY
	} phase_t;

	typedef struct packed {
		logic                      valid;
		logic [FRAME_OFF_BITS-1:0] offset;
		logic [LEN_BITS-1:0]       length;
	} res_beat_t;

endpackage

`default_nettype wire

/* rtl/sync_header_length_deframer.sv */
// ----------------------------------------------------------------------------
// sync_header_length_deframer
// Finds sync-word headed, length-prefixed frames in a byte stream and
// reports each frame's start offset and total length.
// ----------------------------------------------------------------------------
//  channel   dir   handshake               payload
//  in        in    in_valid / in_stall     data_byte, restart
//  out       out   out_valid / out_stall   frame_offset, frame_length
//  config    in    wr_en                   wr_index, wr_data
//
//  one byte per cycle sustained while in_stall is low; a frame's last byte is held
//  in the input register, then its result is captured in the result register
//  the per-byte state update in shld_core sets that byte rate
//  reset clears all frame state and loads the register defaults; no sweep
//  in_stall rises only while the input register holds a byte and a result
//  is waiting under out_stall
// ----------------------------------------------------------------------------
`default_nettype none

module sync_header_length_deframer #(
	parameter int unsigned OFFSET_BITS = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [7:0]                             data_byte,
	input  wire logic                                   restart,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [shld_pkg::FRAME_OFF_BITS-1:0]         frame_offset,
	output logic [shld_pkg::LEN_BITS-1:0]               frame_length,
	input  wire logic                                   wr_en,
	input  wire logic [shld_pkg::CFG_INDEX_BITS-1:0]    wr_index,
	input  wire logic [shld_pkg::CFG_DATA_BITS-1:0]     wr_data
);

	logic [shld_pkg::SYNC_BITS-1:0] sync_word_q;
	logic [shld_pkg::OVH_BITS-1:0]  overhead_q;

	logic                           valid_s1;
	logic [7:0]                     data_s1;
	logic                           restart_s1;

	logic                           free;
	logic                           take;
	shld_pkg::res_beat_t            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= shld_pkg::SYNC_WORD_RESET;
			overhead_q  <= shld_pkg::OVH_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				shld_pkg::REG_SYNC_WORD: begin
					sync_word_q <= wr_data[shld_pkg::SYNC_BITS-1:0];
				end
				shld_pkg::REG_LENGTH_OVERHEAD: begin
					overhead_q <= wr_data[shld_pkg::OVH_BITS-1:0];
				end
				default: ;
			endcase
		end
	end

	assign take     = valid_s1 && free;
	assign in_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	shld_core #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.data_byte      (data_s1),
		.restart        (restart_s1),
		.sync_word      (sync_word_q),
		.length_overhead(overhead_q),
		.res            (res)
	);

	shld_obuf u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.free        (free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_offset(frame_offset),
		.frame_length(frame_length)
	);

endmodule

`default_nettype wire

/* rtl/shld_core.sv */
// ----------------------------------------------------------------------------
// shld_core
// Per-byte frame delineation: sync hunt, length capture and body count.
// ----------------------------------------------------------------------------
`default_nettype none

module shld_core #(
	parameter int unsigned OFFSET_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              take,
	input  wire logic [7:0]                        data_byte,
	input  wire logic                              restart,
	input  wire logic [shld_pkg::SYNC_BITS-1:0]    sync_word,
	input  wire logic [shld_pkg::OVH_BITS-1:0]     length_overhead,
	output shld_pkg::res_beat_t                    res
);

	logic [shld_pkg::WINDOW_BITS-1:0] window_q, window_d;
	logic [1:0]                       fill_q, fill_d;
	shld_pkg::phase_t                 phase_q, phase_d;
	logic [7:0]                       len_hi_q, len_hi_d;
	logic [shld_pkg::LEN_BITS-1:0]    total_q, total_d;
	logic [shld_pkg::LEN_BITS-1:0]    rem_q, rem_d;
	logic [OFFSET_BITS-1:0]           start_q, start_d;
	logic [OFFSET_BITS-1:0]           off_q, off_d;

	// state as seen by this byte, after a restart has wiped the frame
	shld_pkg::phase_t                 phase_e;
	logic [shld_pkg::WINDOW_BITS-1:0] window_e;
	logic [1:0]                       fill_e;
	logic [OFFSET_BITS-1:0]           here;
	logic [shld_pkg::SYNC_BITS-1:0]   word;
	logic                             match;
	logic [shld_pkg::OVH_BITS-1:0]    ovh_eff;
	logic [shld_pkg::LEN_BITS-1:0]    len_sum;
	logic                             emit;

	always_comb begin
		phase_e  = restart ? shld_pkg::PH_HUNT : phase_q;
		window_e = restart ? '0 : window_q;
		fill_e   = restart ? '0 : fill_q;
		here     = restart ? '0 : off_q;
		word     = {window_e, data_byte};
		match    = (fill_e == shld_pkg::FILL_FULL) && (word == sync_word);
		ovh_eff  = (length_overhead < shld_pkg::MIN_OVERHEAD) ?
			shld_pkg::MIN_OVERHEAD : length_overhead;
		len_sum  = shld_pkg::LEN_BITS'({len_hi_q, data_byte})
			+ shld_pkg::LEN_BITS'(ovh_eff);
	end

	// next phase
	always_comb begin
		phase_d = phase_e;
		unique case (phase_e)
			shld_pkg::PH_HUNT: begin
				if (match) phase_d = shld_pkg::PH_LEN_HI;
			end
			shld_pkg::PH_LEN_HI: begin
				phase_d = shld_pkg::PH_LEN_LO;
			end
			shld_pkg::PH_LEN_LO: begin
				if (len_sum <= shld_pkg::LEN_BITS'(shld_pkg::MIN_OVERHEAD)) begin
					phase_d = shld_pkg::PH_HUNT;
				end else begin
					phase_d = shld_pkg::PH_BODY;
				end
			end
			shld_pkg::PH_BODY: begin
				if (rem_q <= shld_pkg::LEN_BITS'(1)) phase_d = shld_pkg::PH_HUNT;
			end
			default: phase_d = shld_pkg::PH_HUNT;
		endcase
	end

	// datapath and result
	always_comb begin
		window_d = window_e;
		fill_d   = fill_e;
		len_hi_d = len_hi_q;
		total_d  = total_q;
		rem_d    = rem_q;
		start_d  = start_q;
		off_d    = here + OFFSET_BITS'(1);
		emit     = 1'b0;
		unique case (phase_e)
			shld_pkg::PH_HUNT: begin
				if (match) begin
					start_d  = here - OFFSET_BITS'(shld_pkg::SYNC_LEAD);
					window_d = '0;
					fill_d   = '0;
				end else begin
					window_d = word[shld_pkg::WINDOW_BITS-1:0];
					if (fill_e != shld_pkg::FILL_FULL) fill_d = fill_e + 2'd1;
				end
			end
			shld_pkg::PH_LEN_HI: begin
				len_hi_d = data_byte;
			end
			shld_pkg::PH_LEN_LO: begin
				total_d = len_sum;
				if (len_sum <= shld_pkg::LEN_BITS'(shld_pkg::MIN_OVERHEAD)) begin
					emit = 1'b1;
				end else begin
					rem_d = len_sum - shld_pkg::LEN_BITS'(shld_pkg::MIN_OVERHEAD);
				end
			end
			shld_pkg::PH_BODY: begin
				if (rem_q <= shld_pkg::LEN_BITS'(1)) begin
					emit = 1'b1;
				end else begin
					rem_d = rem_q - shld_pkg::LEN_BITS'(1);
				end
			end
			default: emit = 1'b0;
		endcase
		res.valid  = take && emit;
		res.offset = shld_pkg::FRAME_OFF_BITS'(start_d);
		res.length = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
			phase_q  <= shld_pkg::PH_HUNT;
			len_hi_q <= '0;
			total_q  <= '0;
			rem_q    <= '0;
			start_q  <= '0;
			off_q    <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			len_hi_q <= len_hi_d;
			rem_q    <= rem_d;
			start_q  <= start_d;
			off_q    <= off_d;
			if (emit) begin
				window_q <= '0;
				fill_q   <= '0;
				total_q  <= '0;
			end else begin
				window_q <= window_d;
				fill_q   <= fill_d;
				total_q  <= total_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_window_idle_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != shld_pkg::PH_HUNT) |-> (fill_q == 2'd0 && window_q == '0))
		else $error("sync window not cleared while inside a frame");

	a_body_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == shld_pkg::PH_BODY) |-> (rem_q != '0))
		else $error("body count reached zero without ending the frame");

	a_result_only_at_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!restart && (phase_q == shld_pkg::PH_LEN_LO
			|| phase_q == shld_pkg::PH_BODY)))
		else $error("result raised outside a frame end");

	a_offset_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !restart) |=> (off_q == $past(off_q) + OFFSET_BITS'(1)))
		else $error("byte offset did not advance by one");

	a_offset_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take && restart) |=> (off_q == OFFSET_BITS'(1)))
		else $error("restart beat did not take offset zero");
`endif

endmodule

`default_nettype wire

/* rtl/shld_obuf.sv */
// ----------------------------------------------------------------------------
// shld_obuf
// Result register: holds one frame result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module shld_obuf (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire shld_pkg::res_beat_t                   res,
	output logic                                       free,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [shld_pkg::FRAME_OFF_BITS-1:0]        frame_offset,
	output logic [shld_pkg::LEN_BITS-1:0]              frame_length
);

	logic                                 valid_q;
	logic [shld_pkg::FRAME_OFF_BITS-1:0]  offset_q;
	logic [shld_pkg::LEN_BITS-1:0]        length_q;

	// register can take a new result when empty or being drained this cycle
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && res.valid) begin
			offset_q <= res.offset;
			length_q <= res.length;
		end
	end

	assign out_valid    = valid_q;
	assign frame_offset = offset_q;
	assign frame_length = length_q;

endmodule

`default_nettype wire

/* tb/sv/tb_sync_header_length_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_header_length_deframer
// Self-checking bench for the sync header / length deframer. A table of
// directed beats comes first, then random register settings with mostly
// well-formed frames, then a frame of the largest length cut short by a
// restart. An in-bench model predicts each frame report not typed in the
// directed table, and all reports are checked in order.
// ----------------------------------------------------------------------------

module tb_sync_header_length_deframer;

	localparam logic [shld_pkg::CFG_INDEX_BITS-1:0] REG_SYNC    = shld_pkg::REG_SYNC_WORD;
	localparam logic [shld_pkg::CFG_INDEX_BITS-1:0] REG_OVH     =
		shld_pkg::REG_LENGTH_OVERHEAD;
	localparam logic [shld_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [shld_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

	localparam int    RANDOM_BEATS    = 1920;
	localparam int    LONG_BODY_BEATS = 24;
	localparam int    SETTLE_CYCLES   = 6;
	localparam int    MAX_GAP         = 10;
	localparam longint LIMIT_NS       = 80_000_000;

	typedef struct packed {
		logic [shld_pkg::FRAME_OFF_BITS-1:0] offset;
		logic [shld_pkg::LEN_BITS-1:0]       length;
	} frame_t;

	typedef enum logic {
		ROW_BEAT,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                           kind;
		logic [7:0]                          data;
		logic                                rst;
		logic [shld_pkg::CFG_INDEX_BITS-1:0] idx;
		logic [shld_pkg::CFG_DATA_BITS-1:0]  val;
		logic                                chk;
		logic [shld_pkg::FRAME_OFF_BITS-1:0] off;
		logic [shld_pkg::LEN_BITS-1:0]       len;
	} row_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic [7:0]                          data_byte;
	logic                                restart;
	logic                                out_valid;
	logic                                out_stall;
	logic [shld_pkg::FRAME_OFF_BITS-1:0] frame_offset;
	logic [shld_pkg::LEN_BITS-1:0]       frame_length;
	logic                                wr_en;
	logic [shld_pkg::CFG_INDEX_BITS-1:0] wr_index;
	logic [shld_pkg::CFG_DATA_BITS-1:0]  wr_data;

	sync_header_length_deframer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_offset (frame_offset),
		.frame_length (frame_length),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// model copy of the registers and the frame state
	logic [shld_pkg::SYNC_BITS-1:0]      cfg_sync;
	logic [shld_pkg::OVH_BITS-1:0]       cfg_ovh;
	logic [shld_pkg::WINDOW_BITS-1:0]    p_window;
	logic [1:0]                          p_fill;
	shld_pkg::phase_t                    p_phase;
	logic [7:0]                          p_len_hi;
	logic [shld_pkg::LEN_BITS-1:0]       p_total;
	logic [shld_pkg::LEN_BITS-1:0]       p_remain;
	logic [shld_pkg::FRAME_OFF_BITS-1:0] p_start;
	logic [shld_pkg::FRAME_OFF_BITS-1:0] p_offset;

	frame_t frames_due[$];
	frame_t due_frame;
	row_t   directed_rows[$];

	int  fail_count     = 0;
	int  frames_checked = 0;
	int  beats_sent     = 0;
	int  writes_done    = 0;
	bit  in_gaps_on     = 1'b1;
	bit  out_gaps_on    = 1'b1;

	function automatic void drop_frame();
		p_window = '0;
		p_fill   = '0;
		p_phase  = shld_pkg::PH_HUNT;
		p_len_hi = '0;
		p_total  = '0;
		p_remain = '0;
	endfunction

	// one byte through the model; returns 1 when the byte closes a frame
	function automatic logic deframe_byte(input logic [7:0] b, input logic rs,
			output frame_t res);
		logic [shld_pkg::FRAME_OFF_BITS-1:0] here;
		logic [shld_pkg::SYNC_BITS-1:0]      word;
		logic [shld_pkg::OVH_BITS-1:0]       ovh;
		logic                                hit;
		hit = 1'b0;
		res = '0;
		if (rs) begin
			drop_frame();
			p_offset = '0;
		end
		here = p_offset;
		case (p_phase)
			shld_pkg::PH_HUNT: begin
				word = {p_window, b};
				if (p_fill == shld_pkg::FILL_FULL && word == cfg_sync) begin
					p_start  = here - shld_pkg::FRAME_OFF_BITS'(shld_pkg::SYNC_LEAD);
					p_window = '0;
					p_fill   = '0;
					p_phase  = shld_pkg::PH_LEN_HI;
				end else begin
					p_window = word[shld_pkg::WINDOW_BITS-1:0];
					if (p_fill != shld_pkg::FILL_FULL)
						p_fill = p_fill + 2'd1;
				end
			end
			shld_pkg::PH_LEN_HI: begin
				p_len_hi = b;
				p_phase  = shld_pkg::PH_LEN_LO;
			end
			shld_pkg::PH_LEN_LO: begin
				// sync and length bytes are already in, so never below the minimum
				ovh     = (cfg_ovh < shld_pkg::MIN_OVERHEAD) ? shld_pkg::MIN_OVERHEAD : cfg_ovh;
				p_total = {1'b0, p_len_hi, b} + {9'd0, ovh};
				if (p_total <= {9'd0, shld_pkg::MIN_OVERHEAD}) begin
					hit = 1'b1;
				end else begin
					p_remain = p_total - {9'd0, shld_pkg::MIN_OVERHEAD};
					p_phase  = shld_pkg::PH_BODY;
				end
			end
			default: begin
				if (p_remain <= 17'd1)
					hit = 1'b1;
				else
					p_remain = p_remain - 17'd1;
			end
		endcase
		if (hit) begin
			res.offset = p_start;
			res.length = p_total;
			drop_frame();
		end
		p_offset = here + 32'd1;
		return hit;
	endfunction

	// wait for every report in flight, then let the pipeline run dry
	task automatic settle();
		in_valid <= 1'b0;
		wr_en    <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [shld_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [shld_pkg::CFG_DATA_BITS-1:0] val);
		settle();
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(posedge clk);
		if (idx == shld_pkg::REG_SYNC_WORD)
			cfg_sync = val;
		else if (idx == shld_pkg::REG_LENGTH_OVERHEAD)
			cfg_ovh = val[shld_pkg::OVH_BITS-1:0];
		writes_done++;
	endtask

	task automatic send_beat(input logic [7:0] b, input logic rs, input logic chk,
			input frame_t typed);
		int unsigned gap;
		frame_t      pred;
		logic        got;
		gap = in_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		wr_en <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		restart   <= rs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = deframe_byte(b, rs, pred);
		if (chk)
			frames_due.push_back(typed);
		else if (got)
			frames_due.push_back(pred);
		beats_sent++;
	endtask

	task automatic pick_settings();
		logic [shld_pkg::SYNC_BITS-1:0] sw;
		logic [shld_pkg::OVH_BITS-1:0]  ov;
		int unsigned                    which;
		case ($urandom_range(0, 5))
			0:       sw = shld_pkg::SYNC_WORD_RESET;
			1:       sw = '0;
			2:       sw = '1;
			default: sw = $urandom;
		endcase
		case ($urandom_range(0, 7))
			0:       ov = shld_pkg::OVH_BITS'($urandom_range(0, 5));
			1:       ov = shld_pkg::MIN_OVERHEAD;
			2:       ov = '1;
			default: ov = shld_pkg::OVH_BITS'($urandom_range(6, 24));
		endcase
		which = $urandom_range(0, 3);
		if (which != 1)
			cfg_write(REG_SYNC, sw);
		if (which != 0)
			cfg_write(REG_OVH, {24'd0, ov});
		if ($urandom_range(0, 3) == 0)
			cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom);
	endtask

	// noise, sync, length and body; sometimes a broken sync or a restart mid-frame
	task automatic send_frame();
		int unsigned                    noise;
		int unsigned                    bit_pos;
		int                             body;
		int                             cut;
		int                             i;
		logic [15:0]                    len;
		logic [shld_pkg::OVH_BITS-1:0]  ovh_eff;
		logic [shld_pkg::SYNC_BITS-1:0] hdr;
		noise = $urandom_range(0, 6);
		for (i = 0; i < noise; i++)
			send_beat(8'($urandom), $urandom_range(0, 29) == 0, 1'b0, '0);
		hdr = cfg_sync;
		if ($urandom_range(0, 14) == 0) begin
			bit_pos      = $urandom_range(0, shld_pkg::SYNC_BITS - 1);
			hdr[bit_pos] = ~hdr[bit_pos];
		end
		send_beat(hdr[31:24], $urandom_range(0, 9) == 0, 1'b0, '0);
		send_beat(hdr[23:16], 1'b0, 1'b0, '0);
		send_beat(hdr[15:8], 1'b0, 1'b0, '0);
		send_beat(hdr[7:0], 1'b0, 1'b0, '0);
		len[15:8] = ($urandom_range(0, 19) == 0) ? 8'd1 : 8'd0;
		len[7:0]  = (len[15:8] != 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
		send_beat(len[15:8], 1'b0, 1'b0, '0);
		send_beat(len[7:0], 1'b0, 1'b0, '0);
		ovh_eff = (cfg_ovh < shld_pkg::MIN_OVERHEAD) ? shld_pkg::MIN_OVERHEAD : cfg_ovh;
		body    = int'(len) + int'(ovh_eff) - int'(shld_pkg::MIN_OVERHEAD);
		cut     = (body > 0 && $urandom_range(0, 11) == 0) ? $urandom_range(0, body - 1) : -1;
		for (i = 0; i < body; i++) begin
			if (i == cut) begin
				send_beat(8'($urandom), 1'b1, 1'b0, '0);
				break;
			end
			send_beat(8'($urandom), 1'b0, 1'b0, '0);
		end
	endtask

	// receiver: random hold-off before each beat it takes
	initial begin
		int unsigned n;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			n = out_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(out_valid && !out_stall))
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected frame report: offset %h length %0d",
						frame_offset, frame_length);
			end else begin
				due_frame = frames_due.pop_front();
				frames_checked++;
				if (due_frame.offset !== frame_offset || due_frame.length !== frame_length) begin
					fail_count++;
					if (fail_count <= 10)
						$display("frame %0d: offset exp %h got %h, length exp %0d got %0d",
							frames_checked, due_frame.offset, frame_offset,
							due_frame.length, frame_length);
				end
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("timed out with %0d frame reports outstanding", frames_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		frame_t typed;
		int     target;
		int     long_beats;
		int     i;

		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		data_byte <= '0;
		restart   <= 1'b0;
		wr_en     <= 1'b0;
		wr_index  <= REG_SYNC;
		wr_data   <= '0;
		cfg_sync  = shld_pkg::SYNC_WORD_RESET;
		cfg_ovh   = shld_pkg::OVH_RESET;
		drop_frame();
		p_start   = '0;
		p_offset  = '0;

		// kind, byte, restart, reg index, reg value, typed check, offset, length
		// default registers: one full frame with the sync word inside its body
		directed_rows.push_back('{ROW_BEAT, 8'hA5, 1'b1, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h5A, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'hA5, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h5A, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h00, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h00, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'hA5, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h5A, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'hA5, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h5A, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'hFF, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h00, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'hFF, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h00, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h55, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'hAA, 1'b0, REG_SYNC, 32'd0, 1'b1, 32'd0, 17'd16});
		// restart, then a frame cut off after its length high byte
		directed_rows.push_back('{ROW_BEAT, 8'hA5, 1'b1, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h5A, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'hA5, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h5A, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h12, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		// registers changed mid-frame, spare indexes must be ignored
		directed_rows.push_back('{ROW_CFG, 8'h00, 1'b0, REG_SYNC, 32'h0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_CFG, 8'h00, 1'b0, REG_OVH, 32'h0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_CFG, 8'h00, 1'b0, REG_SPARE_2, 32'hFFFF_FFFF, 1'b0, 32'd0,
			17'd0});
		directed_rows.push_back('{ROW_CFG, 8'h00, 1'b0, REG_SPARE_3, 32'hFFFF_FFFF, 1'b0, 32'd0,
			17'd0});
		// all-zero sync: the first three bytes after restart cannot match
		directed_rows.push_back('{ROW_BEAT, 8'h00, 1'b1, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h00, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h00, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h00, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		// overhead below minimum: frame ends on the length low byte
		directed_rows.push_back('{ROW_BEAT, 8'h00, 1'b0, REG_SYNC, 32'd0, 1'b0, 32'd0, 17'd0});
		directed_rows.push_back('{ROW_BEAT, 8'h00, 1'b0, REG_SYNC, 32'd0, 1'b1, 32'd0, 17'd6});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < directed_rows.size(); i++) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				cfg_write(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				typed.offset = directed_rows[i].off;
				typed.length = directed_rows[i].len;
				send_beat(directed_rows[i].data, directed_rows[i].rst,
					directed_rows[i].chk, typed);
			end
		end

		target = beats_sent + RANDOM_BEATS;
		while (beats_sent < target) begin
			pick_settings();
			in_gaps_on  = ($urandom_range(0, 4) != 0);
			out_gaps_on = ($urandom_range(0, 4) != 0);
			i = beats_sent + $urandom_range(100, 250);
			while (beats_sent < i)
				send_frame();
		end

		// largest length field with the largest overhead, back to back, dropped by a restart
		cfg_write(REG_OVH, {24'd0, 8'hFF});
		cfg_write(REG_SYNC, $urandom);
		in_gaps_on  = 1'b0;
		out_gaps_on = 1'b1;
		long_beats  = beats_sent;
		send_beat(cfg_sync[31:24], 1'b1, 1'b0, '0);
		send_beat(cfg_sync[23:16], 1'b0, 1'b0, '0);
		send_beat(cfg_sync[15:8], 1'b0, 1'b0, '0);
		send_beat(cfg_sync[7:0], 1'b0, 1'b0, '0);
		send_beat(8'hFF, 1'b0, 1'b0, '0);
		send_beat(8'hFF, 1'b0, 1'b0, '0);
		for (i = 0; i < LONG_BODY_BEATS; i++)
			send_beat(8'($urandom), 1'b0, 1'b0, '0);
		send_beat(8'($urandom), 1'b1, 1'b0, '0);
		long_beats = beats_sent - long_beats;

		settle();
		$display("%0d beats sent (%0d in a maximum-length frame cut by a restart), %0d reports checked",
			beats_sent, long_beats, frames_checked);
		$display("%0d register writes over directed, random and maximum-length phases",
			writes_done);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
